/* rtl/ssn_pkg.sv */
`default_nettype none
package ssn_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int UNIT_LEN        = 16384;

   // configuration register indexes
   localparam logic CSR_NEIGHBOUR_MODE = 1'b0;
   localparam logic CSR_DEPTH_STEP     = 1'b1;

   // neighbour modes
   localparam logic [1:0] MODE_BOTH  = 2'd0;
   localparam logic [1:0] MODE_PREV  = 2'd1;
   localparam logic [1:0] MODE_NEXT  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, decodes as both

   typedef struct packed {
      logic signed [31:0] abscissa_value;
      logic signed [31:0] target_height;
      logic signed [31:0] earlier_height;
      logic signed [31:0] later_height;
      logic               final_point;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
      logic               strip_end;
   } rsp_payload_type;

endpackage
`default_nettype wire

/* rtl/ssn_req_if.sv */
`default_nettype none
interface ssn_req_if import ssn_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssn_rsp_if import ssn_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/surface_strip_normal_unit_core.sv */
`default_nettype none
// Channel    Dir  Payload                                        Handshake
// req_chan   in   abscissa, target/earlier/later height, final   valid/ready
// rsp_chan   out  normal_x/y/z (Q1.14), degenerate, strip_end     valid/ready
// csr_*      in   index 0 neighbour_mode, index 1 depth_step     write enable
//
// One request in flight: req ready only in idle. A normal runs multiply, shift,
// squares, root, divide and output steps (a zero vector skips from shift to
// output) on the one shared 32x32 multiplier / root / divide datapath; a final
// point with two normals runs them twice. A strip's first point gives no normal.
// Sync active-high reset clears window and control. A full output register
// stalls the engine at its output step only.
module surface_strip_normal_unit_core
   import ssn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ssn_req_if.sink          req_chan,
   ssn_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);

   localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL   = 7'b0000010,
      S_SHIFT = 7'b0000100,
      S_SQR   = 7'b0001000,
      S_ROOT  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] ci_ff, ci_in;

   // configuration
   logic [1:0]         mode_ff, mode_in;
   logic signed [31:0] dz_ff, dz_in;

   // strip window
   logic signed [32:0] wa0_ff, wa0_in, wa1_ff, wa1_in;
   logic signed [32:0] wh0_ff, wh0_in, wh1_ff, wh1_in;
   logic signed [32:0] held_ff, held_in;
   logic [1:0]         seen_ff, seen_in;

   // current and pending normal jobs
   logic signed [32:0] jdx_ff, jdx_in, jdy_ff, jdy_in, jds_ff, jds_in;
   logic               jend_ff, jend_in;
   logic signed [32:0] pdx_ff, pdx_in, pdy_ff, pdy_in, pds_ff, pds_in;
   logic               pend_ff, pend_in;

   // datapath
   logic [63:0] p_ff [3];
   logic [63:0] p_in [3];
   logic [63:0] sq_ff, sq_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] r_ff, r_in, b_ff, b_in;
   logic [31:0] len_ff, len_in;
   logic [47:0] num_ff, num_in, dv_ff, dv_in;
   logic [15:0] q_ff, q_in;
   logic [15:0] res_ff [3];
   logic [15:0] res_in [3];
   logic        deg_ff, deg_in;

   // output register
   logic            ovalid_ff, ovalid_in;
   rsp_payload_type opay_ff, opay_in;

   // request decode
   logic signed [32:0] x_s, y_s, ye_s, yl_s, ds_s;
   logic               accept, out_free;

   // shared multiplier
   logic [31:0] mul_a, mul_b, ax, ay, as_m, az;
   logic [63:0] mul_prod;
   logic        neg [3];

   logic [32:0] dz_ext;
   logic [63:0] rb_sum;
   logic [15:0] q_next, q_cap;
   logic        ge;

   assign x_s  = 33'($signed(req_chan.payload.abscissa_value[CW-1:0]));
   assign y_s  = 33'($signed(req_chan.payload.target_height[CW-1:0]));
   assign ye_s = 33'($signed(req_chan.payload.earlier_height[CW-1:0]));
   assign yl_s = 33'($signed(req_chan.payload.later_height[CW-1:0]));

   always_comb begin
      case (mode_ff)
         MODE_PREV: ds_s = y_s - ye_s;
         MODE_NEXT: ds_s = yl_s - y_s;
         default:   ds_s = yl_s - ye_s;
      endcase
   end

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = ovalid_ff;
   assign rsp_chan.payload = opay_ff;
   assign out_free         = !ovalid_ff || rsp_chan.ready;

   // magnitudes all fit 32 bits
   assign dz_ext = 33'(dz_ff);
   assign ax     = jdx_ff[32] ? 32'(-jdx_ff) : jdx_ff[31:0];
   assign ay     = jdy_ff[32] ? 32'(-jdy_ff) : jdy_ff[31:0];
   assign as_m   = jds_ff[32] ? 32'(-jds_ff) : jds_ff[31:0];
   assign az     = dz_ext[32] ? 32'(-dz_ext) : dz_ext[31:0];

   assign neg[0] = jdy_ff[32] ^ dz_ff[31];
   assign neg[1] = !(jdx_ff[32] ^ dz_ff[31]);
   assign neg[2] = jdx_ff[32] ^ jds_ff[32];

   always_comb begin
      mul_a = ax;
      mul_b = az;
      if (state_ff == S_SQR) begin
         mul_a = p_ff[ci_ff][31:0];
         mul_b = p_ff[ci_ff][31:0];
      end else begin
         case (cnt_ff[1:0])
            2'd0:    begin mul_a = ay; mul_b = az;   end
            2'd1:    begin mul_a = ax; mul_b = az;   end
            default: begin mul_a = ax; mul_b = as_m; end
         endcase
      end
   end
   assign mul_prod = 64'(mul_a) * 64'(mul_b);

   assign rb_sum = r_ff + b_ff;
   assign ge     = (num_ff >= dv_ff);
   assign q_next = {q_ff[14:0], ge};
   assign q_cap  = (q_next > 16'(UNIT_LEN)) ? 16'(UNIT_LEN) : q_next;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ci_in     = ci_ff;
      mode_in   = mode_ff;
      dz_in     = dz_ff;
      wa0_in    = wa0_ff;  wa1_in = wa1_ff;
      wh0_in    = wh0_ff;  wh1_in = wh1_ff;
      held_in   = held_ff;
      seen_in   = seen_ff;
      jdx_in    = jdx_ff;  jdy_in = jdy_ff;  jds_in = jds_ff;  jend_in = jend_ff;
      pdx_in    = pdx_ff;  pdy_in = pdy_ff;  pds_in = pds_ff;  pend_in = pend_ff;
      p_in      = p_ff;
      sq_in     = sq_ff;
      sum_in    = sum_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      len_in    = len_ff;
      num_in    = num_ff;
      dv_in     = dv_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      deg_in    = deg_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      opay_in   = opay_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_NEIGHBOUR_MODE: mode_in = csr_write_data[1:0];
            default:            dz_in   = $signed(csr_write_data);
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wa0_in  = x_s;
               wh0_in  = y_s;
               held_in = ds_s;
               if (seen_ff == 2'd0) begin
                  seen_in = req_chan.payload.final_point ? 2'd0 : 2'd1;
               end else begin
                  // previous point: one-sided at strip start, else central
                  jdx_in  = x_s - ((seen_ff == 2'd1) ? wa0_ff : wa1_ff);
                  jdy_in  = y_s - ((seen_ff == 2'd1) ? wh0_ff : wh1_ff);
                  jds_in  = held_ff;
                  jend_in = 1'b0;
                  // last point, one-sided backward
                  pdx_in  = x_s - wa0_ff;
                  pdy_in  = y_s - wh0_ff;
                  pds_in  = ds_s;
                  pend_in = req_chan.payload.final_point;
                  wa1_in  = wa0_ff;
                  wh1_in  = wh0_ff;
                  seen_in = req_chan.payload.final_point ? 2'd0 : 2'd2;
                  cnt_in  = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            p_in[cnt_ff[1:0]] = mul_prod;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (p_ff[0] == '0 && p_ff[1] == '0 && p_ff[2] == '0) begin
               res_in[0] = '0;
               res_in[1] = '0;
               res_in[2] = '0;
               deg_in    = 1'b1;
               state_in  = S_OUT;
            end else if ((p_ff[0][63:31] | p_ff[1][63:31] | p_ff[2][63:31]) != '0) begin
               p_in[0] = p_ff[0] >> 1;
               p_in[1] = p_ff[1] >> 1;
               p_in[2] = p_ff[2] >> 1;
            end else begin
               deg_in   = 1'b0;
               ci_in    = '0;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            // square into sq, accumulate it in the next cycle
            sq_in = mul_prod;
            if (cnt_ff != 6'd0) begin
               sum_in = sum_ff + sq_ff;
            end
            if (ci_ff != 2'd2) begin
               ci_in = ci_ff + 2'd1;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               r_in     = '0;
               b_in     = 64'd1 << 62;
               cnt_in   = '0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (sum_ff >= rb_sum) begin
               sum_in = sum_ff - rb_sum;
               r_in   = (r_ff >> 1) + b_ff;
            end else begin
               r_in   = r_ff >> 1;
            end
            b_in   = b_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               ci_in    = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (cnt_ff == 6'd0) begin
               // round(c * 16384 / len) as (c*32768 + len) / (2*len)
               len_in = (r_ff[31:0] == '0) ? 32'd1 : r_ff[31:0];
               num_in = {2'b00, p_ff[ci_ff][30:0], 15'd0} + 48'(len_in);
               dv_in  = {len_in, 16'd0};
               q_in   = '0;
               cnt_in = 6'd1;
            end else begin
               if (ge) begin
                  num_in = num_ff - dv_ff;
               end
               dv_in  = dv_ff >> 1;
               q_in   = q_next;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd16) begin
                  res_in[ci_ff] = (neg[ci_ff] && q_cap != '0) ? 16'(-q_cap) : q_cap;
                  cnt_in = '0;
                  if (ci_ff == 2'd2) begin
                     state_in = S_OUT;
                  end else begin
                     ci_in = ci_ff + 2'd1;
                  end
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               ovalid_in           = 1'b1;
               opay_in.normal_x    = res_ff[0];
               opay_in.normal_y    = res_ff[1];
               opay_in.normal_z    = res_ff[2];
               opay_in.degenerate  = deg_ff;
               opay_in.strip_end   = jend_ff;
               cnt_in              = '0;
               if (pend_ff) begin
                  jdx_in   = pdx_ff;
                  jdy_in   = pdy_ff;
                  jds_in   = pds_ff;
                  jend_in  = 1'b1;
                  pend_in  = 1'b0;
                  state_in = S_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         ci_ff     <= '0;
         mode_ff   <= MODE_BOTH;
         dz_ff     <= 32'sd65536;
         wa0_ff    <= '0;
         wa1_ff    <= '0;
         wh0_ff    <= '0;
         wh1_ff    <= '0;
         held_ff   <= '0;
         seen_ff   <= '0;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ci_ff     <= ci_in;
         mode_ff   <= mode_in;
         dz_ff     <= dz_in;
         wa0_ff    <= wa0_in;
         wa1_ff    <= wa1_in;
         wh0_ff    <= wh0_in;
         wh1_ff    <= wh1_in;
         held_ff   <= held_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      jdx_ff  <= jdx_in;
      jdy_ff  <= jdy_in;
      jds_ff  <= jds_in;
      jend_ff <= jend_in;
      pdx_ff  <= pdx_in;
      pdy_ff  <= pdy_in;
      pds_ff  <= pds_in;
      p_ff    <= p_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
      len_ff  <= len_in;
      num_ff  <= num_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
      deg_ff  <= deg_in;
      opay_ff <= opay_in;
   end

endmodule
`default_nettype wire

/* sim/ssn_normal_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ssn_normal_checker
   import ssn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ssn_req_if               req_mon,
   ssn_rsp_if               rsp_mon,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data,
   output int               fail_count,
   output int               pending,
   output int               normals_seen,
   output int               degenerate_seen
);

   logic [1:0]         mode_reg;
   logic signed [31:0] depth_reg;
   longint             win_x [2];
   longint             win_y [2];
   longint             held_ds;
   int                 pts;
   rsp_payload_type    normals_due [$];

   assign pending = normals_due.size();

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // unit normal of (dy*dz, -dx*dz, dx*ds), Q1.14
   function automatic rsp_payload_type unit_normal(input longint dx, input longint dy,
                                                   input longint ds, input logic last_flag);
      rsp_payload_type n;
      longint      dz;
      logic [63:0] p [3];
      logic [63:0] c [3];
      logic [63:0] q [3];
      logic        neg [3];
      logic [63:0] big, sum, len;
      int          sh;
      dz = longint'(depth_reg);
      p[0] = magnitude(dy) * magnitude(dz);
      p[1] = magnitude(dx) * magnitude(dz);
      p[2] = magnitude(dx) * magnitude(ds);
      neg[0] = (dy < 0) != (dz < 0);
      neg[1] = !((dx < 0) != (dz < 0));
      neg[2] = (dx < 0) != (ds < 0);
      n = '0;
      n.strip_end = last_flag;
      if (p[0] == 0 && p[1] == 0 && p[2] == 0) begin
         n.degenerate = 1'b1;
         return n;
      end
      big = p[0];
      if (p[1] > big) big = p[1];
      if (p[2] > big) big = p[2];
      sh = 0;
      while ((big >> sh) >= (64'd1 << 31)) sh++;
      for (int i = 0; i < 3; i++) c[i] = p[i] >> sh;
      sum = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      len = root_floor(sum);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         q[i] = (c[i] * (2 * UNIT_LEN) + len) / (2 * len);
         if (q[i] > UNIT_LEN) q[i] = UNIT_LEN;
         if (neg[i] && q[i] != 0) q[i] = 64'h10000 - q[i];
      end
      n.normal_x = q[0][15:0];
      n.normal_y = q[1][15:0];
      n.normal_z = q[2][15:0];
      return n;
   endfunction

   task automatic take_point(input req_payload_type r);
      longint x, y, ds;
      int     back;
      x = longint'(r.abscissa_value);
      y = longint'(r.target_height);
      case (mode_reg)
         MODE_PREV: ds = y - longint'(r.earlier_height);
         MODE_NEXT: ds = longint'(r.later_height) - y;
         default:   ds = longint'(r.later_height) - longint'(r.earlier_height);
      endcase
      if (pts == 0) begin
         win_x[0] = x;
         win_y[0] = y;
         held_ds = ds;
         pts = r.final_point ? 0 : 1;
         return;
      end
      back = (pts == 1) ? 0 : 1;
      normals_due.push_back(unit_normal(x - win_x[back], y - win_y[back], held_ds, 1'b0));
      win_x[1] = win_x[0];
      win_y[1] = win_y[0];
      win_x[0] = x;
      win_y[0] = y;
      held_ds = ds;
      pts = 2;
      if (r.final_point) begin
         normals_due.push_back(unit_normal(x - win_x[1], y - win_y[1], ds, 1'b1));
         pts = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type got, want;
      if (reset) begin
         mode_reg  <= MODE_BOTH;
         depth_reg <= 32'sd65536;
         win_x = '{0, 0};
         win_y = '{0, 0};
         held_ds = 0;
         pts = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) take_point(req_mon.payload);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            normals_seen++;
            if (got.degenerate) degenerate_seen++;
            if (normals_due.size() == 0) begin
               report("normal with no request behind it");
            end else begin
               want = normals_due.pop_front();
               if (got.normal_x !== want.normal_x)
                  report($sformatf("normal_x %0d, want %0d", got.normal_x, want.normal_x));
               if (got.normal_y !== want.normal_y)
                  report($sformatf("normal_y %0d, want %0d", got.normal_y, want.normal_y));
               if (got.normal_z !== want.normal_z)
                  report($sformatf("normal_z %0d, want %0d", got.normal_z, want.normal_z));
               if (got.degenerate !== want.degenerate)
                  report($sformatf("degenerate %b, want %b", got.degenerate, want.degenerate));
               if (got.strip_end !== want.strip_end)
                  report($sformatf("strip_end %b, want %b", got.strip_end, want.strip_end));
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_NEIGHBOUR_MODE) mode_reg <= csr_write_data[1:0];
            else depth_reg <= csr_write_data;
         end
      end
   end

   initial begin
      fail_count = 0;
      normals_seen = 0;
      degenerate_seen = 0;
   end

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import ssn_pkg::*;

   localparam int IDLE_SETTLE = 400;   // > two normals through the shared datapath
   localparam int STALL_LIMIT = 8000;  // cycles with no request or normal moving
   localparam int HOLD_CYCLES = 1500;  // long receiver hold-off

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   ssn_req_if req_chan ();
   ssn_rsp_if rsp_chan ();

   int fail_count, pending, normals_seen, degenerate_seen;
   int src_idle, snk_idle;   // percent of cycles idle / stalled
   int points_sent;
   bit rsp_hold;
   int quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   surface_strip_normal_unit_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ssn_normal_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .normals_seen     (normals_seen),
      .degenerate_seen  (degenerate_seen)
   );

   // receiver: random stall, or a full hold-off while rsp_hold is set
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= snk_idle);
   end

   // watchdog: a long run with nothing accepted means the block hung
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // one request; valid stays up across back-to-back requests
   task automatic send_point(input req_payload_type p);
      while ($urandom_range(99) < src_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (!req_chan.ready);
      points_sent++;
   endtask

   task automatic drop_valid();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_payload_type point(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] ye, input logic [31:0] yl,
                                             input logic last_pt);
      req_payload_type p;
      p.abscissa_value = x;
      p.target_height  = y;
      p.earlier_height = ye;
      p.later_height   = yl;
      p.final_point    = last_pt;
      return p;
   endfunction

   // block must be idle: all normals back, then the engine's own latency
   task automatic write_reg(input logic idx, input logic [31:0] data);
      wait (pending == 0);
      repeat (IDLE_SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random strip: mostly smooth surfaces, some wild values and flat runs
   task automatic send_strip(input int len);
      int          flavor;
      logic [31:0] x, y, ye, yl;
      flavor = $urandom_range(9);
      x  = $urandom;
      y  = $urandom;
      ye = $urandom;
      yl = $urandom;
      for (int i = 0; i < len; i++) begin
         if (flavor < 6) begin
            x  += $urandom_range(32'h40000);
            y  += $urandom_range(32'h20000) - 32'h10000;
            ye = y + $urandom_range(32'h20000) - 32'h10000;
            yl = y + $urandom_range(32'h20000) - 32'h10000;
         end else if (flavor < 9) begin
            x  = $urandom;
            y  = $urandom;
            ye = $urandom;
            yl = $urandom;
         end
         // flavor 9: repeated point, zero tangent
         send_point(point(x, y, ye, yl, i == len - 1));
      end
   endtask

   task automatic random_phase(input int n_points);
      int target;
      target = points_sent + n_points;
      while (points_sent < target) send_strip($urandom_range(1, 8));
      drop_valid();
   endtask

   localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX_NEG = 32'h8000_0000;

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_NEIGHBOUR_MODE;
      csr_write_data   <= '0;
      src_idle = 0;
      snk_idle = 0;
      rsp_hold = 0;
      points_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings (both neighbours, unit depth)
      send_point(point(32'h0001_0000, 32'h0002_0000, 0, 0, 1'b1)); // lone point: no normal
      send_point(point(0, 0, 0, 32'h0001_0000, 1'b0));             // two-point strip
      send_point(point(32'h0001_0000, 32'h0001_0000, 0, 0, 1'b1));
      send_point(point(5, 5, 5, 5, 1'b0));                         // flat repeats: zero length
      send_point(point(5, 5, 5, 5, 1'b0));
      send_point(point(5, 5, 5, 5, 1'b1));
      send_point(point(MAX_NEG, MAX_NEG, MAX_POS, MAX_NEG, 1'b0)); // field extremes
      send_point(point(MAX_POS, MAX_POS, MAX_NEG, MAX_POS, 1'b0));
      send_point(point(MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, 1'b1)); // last point, mode 0 sign
      send_point(point(0, 0, 32'h0003_0000, 32'h0001_0000, 1'b0));
      send_point(point(32'h0001_0000, 32'h0000_8000, 0, 32'h0002_0000, 1'b0));
      send_point(point(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0, 1'b1));
      drop_valid();
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_PREV));
      write_reg(CSR_DEPTH_STEP, MAX_NEG);
      send_point(point(0, MAX_POS, MAX_NEG, 0, 1'b0));
      send_point(point(MAX_POS, MAX_NEG, MAX_POS, 0, 1'b0));
      send_point(point(1, 2, 3, 4, 1'b1));
      drop_valid();
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_NEXT));
      write_reg(CSR_DEPTH_STEP, MAX_POS);
      send_point(point(0, MAX_NEG, 0, MAX_POS, 1'b0));
      send_point(point(MAX_NEG, 0, 0, MAX_NEG, 1'b1));
      drop_valid();
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_SPARE));   // unused code acts as both neighbours
      write_reg(CSR_DEPTH_STEP, 32'd0);      // no depth: only the z component survives
      send_point(point(0, 0, 0, 32'h0001_0000, 1'b0));
      send_point(point(32'h0001_0000, 32'h0005_0000, 0, 0, 1'b0));
      send_point(point(32'h0002_0000, 0, 7, 7, 1'b1));
      drop_valid();

      // random phases across the idling patterns and register settings
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_BOTH));
      write_reg(CSR_DEPTH_STEP, 32'h0001_0000);
      random_phase(80);

      src_idle = 82;
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_PREV));
      write_reg(CSR_DEPTH_STEP, $urandom);
      random_phase(80);

      src_idle = 0;
      snk_idle = 82;
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_NEXT));
      write_reg(CSR_DEPTH_STEP, 32'hFFFF_0000);
      random_phase(80);

      src_idle = 29;
      snk_idle = 29;
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_SPARE));
      write_reg(CSR_DEPTH_STEP, MAX_POS);
      random_phase(80);

      // backpressure: receiver holds off while requests keep coming
      src_idle = 0;
      snk_idle = 0;
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_BOTH));
      write_reg(CSR_DEPTH_STEP, MAX_NEG);
      fork
         begin
            rsp_hold = 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 0;
         end
         random_phase(80);
      join

      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_PREV));
      write_reg(CSR_DEPTH_STEP, 32'h0000_0001);
      random_phase(80);

      src_idle = 82;
      snk_idle = 82;
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_NEXT));
      write_reg(CSR_DEPTH_STEP, $urandom);
      random_phase(40);

      src_idle = 29;
      snk_idle = 29;
      write_reg(CSR_NEIGHBOUR_MODE, 32'(MODE_BOTH));
      write_reg(CSR_DEPTH_STEP, $urandom);
      random_phase(80);

      // drain; the watchdog bounds this wait
      wait (pending == 0);
      repeat (IDLE_SETTLE) @(posedge clock);

      $display("Sent %0d points over all neighbour modes, depth extremes and idle patterns;",
               points_sent);
      $display("checked %0d normals, %0d of them zero length.", normals_seen, degenerate_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
rtl/ssn_pkg.sv
rtl/ssn_req_if.sv
rtl/surface_strip_normal_unit_core.sv
sim/ssn_normal_checker.sv
sim/tb.sv
